[rtl/largest_divisible_chain_top_assert.svh]
// Assertion macros for the largest divisible chain top module.
`ifndef LARGEST_DIVISIBLE_CHAIN_TOP_ASSERT_SVH
`define LARGEST_DIVISIBLE_CHAIN_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define LDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ldc_pkg.sv]
// Shared constants and controller/datapath interface types.
package ldc_pkg;

	localparam int unsigned VALUE_W       = 31;
	localparam int unsigned MAX_ITEMS_DEF = 32;

	typedef struct packed {
		logic in_ld;
		logic v_wr;
		logic v_wr_in;
		logic dp_init;
		logic vi_ld;
		logic mod_start;
		logic ext_upd;
		logic len_wr;
		logic best_clr;
		logic out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic rd_gt_v;
		logic mod_done;
	} dp_stat_t;

endpackage

[rtl/ldc_mod.sv]
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module ldc_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ldc_pkg::VALUE_W-1:0] dividend,
	input  logic [ldc_pkg::VALUE_W-1:0] divisor,
	output logic                        done,
	output logic                        rem_zero
);
	import ldc_pkg::*;

	localparam int unsigned STEP_W = $clog2(VALUE_W);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [VALUE_W-1:0]  dvd_q;
	logic [VALUE_W-1:0]  dsr_q;
	logic [VALUE_W-1:0]  rem_q;
	logic [VALUE_W:0]    trial;
	logic [VALUE_W-1:0]  rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[VALUE_W-1]};
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = VALUE_W'(trial - {1'b0, dsr_q});
		end else begin
			rem_next = trial[VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VALUE_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

endmodule

[rtl/ldc_dp.sv]
// Datapath: value, length and predecessor memories, chain registers, output data.
module ldc_dp #(
	parameter int unsigned MAX_ITEMS = ldc_pkg::MAX_ITEMS_DEF,
	parameter int unsigned IW        = $clog2(MAX_ITEMS),
	parameter int unsigned CW        = $clog2(MAX_ITEMS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ldc_pkg::dp_cmd_t            cmd,
	output ldc_pkg::dp_stat_t           stat,
	input  logic [ldc_pkg::VALUE_W-1:0] value,
	input  logic [IW-1:0]               rd_addr,
	input  logic [IW-1:0]               wr_addr,
	input  logic [IW-1:0]               i_addr,
	input  logic [IW-1:0]               j_addr,
	output logic [IW-1:0]               best_idx,
	output logic [CW-1:0]               best_len,
	output logic [IW-1:0]               pred_rd,
	output logic [ldc_pkg::VALUE_W-1:0] member
);
	import ldc_pkg::*;

	logic [VALUE_W-1:0] vals_mem [MAX_ITEMS];
	logic [CW-1:0]      lens_mem [MAX_ITEMS];
	logic [IW-1:0]      preds_mem[MAX_ITEMS];

	logic [VALUE_W-1:0] vrd_q;
	logic [CW-1:0]      lrd_q;
	logic [IW-1:0]      prd_q;
	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] vi_q;
	logic [CW-1:0]      li_q;
	logic [IW-1:0]      pi_q;
	logic [CW-1:0]      lj_q;
	logic               dnz_q;
	logic [IW-1:0]      best_q;
	logic [CW-1:0]      bestlen_q;
	logic [VALUE_W-1:0] member_q;
	logic               mod_done;
	logic               rem_zero;
	logic               extend;

	ldc_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (vi_q),
		.divisor  (vrd_q),
		.done     (mod_done),
		.rem_zero (rem_zero)
	);

	// A chain extends only through a nonzero divisor and a strictly longer length.
	assign extend = rem_zero && dnz_q && ((lj_q + 1'b1) > li_q);

	always_ff @(posedge clk) begin
		if (cmd.v_wr) begin
			vals_mem[wr_addr] <= cmd.v_wr_in ? value_q : vrd_q;
		end
		if (cmd.len_wr) begin
			lens_mem[i_addr]  <= li_q;
			preds_mem[i_addr] <= pi_q;
		end
		vrd_q <= vals_mem[rd_addr];
		lrd_q <= lens_mem[rd_addr];
		prd_q <= preds_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.in_ld) begin
			value_q <= value;
		end
		if (cmd.vi_ld) begin
			vi_q <= vrd_q;
		end
		if (cmd.mod_start) begin
			lj_q  <= lrd_q;
			dnz_q <= (vrd_q != '0);
		end
		if (cmd.dp_init) begin
			li_q <= CW'(1);
			pi_q <= i_addr;
		end else if (cmd.ext_upd && mod_done && extend) begin
			li_q <= lj_q + 1'b1;
			pi_q <= j_addr;
		end
		if (cmd.out_ld) begin
			member_q <= vrd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q    <= '0;
			bestlen_q <= '0;
		end else if (cmd.best_clr) begin
			best_q    <= '0;
			bestlen_q <= '0;
		end else if (cmd.len_wr && (li_q > bestlen_q)) begin
			best_q    <= i_addr;
			bestlen_q <= li_q;
		end
	end

	assign stat.rd_gt_v  = (vrd_q > value_q);
	assign stat.mod_done = mod_done;
	assign best_idx      = best_q;
	assign best_len      = bestlen_q;
	assign pred_rd       = prd_q;
	assign member        = member_q;

endmodule

[rtl/ldc_ctrl.sv]
// Controller: sequences insertion, the chain search and the emission of results.
module ldc_ctrl #(
	parameter int unsigned MAX_ITEMS = ldc_pkg::MAX_ITEMS_DEF,
	parameter int unsigned IW        = $clog2(MAX_ITEMS),
	parameter int unsigned CW        = $clog2(MAX_ITEMS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              last_item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              last_member,
	output logic              overflow,
	output ldc_pkg::dp_cmd_t  cmd,
	input  ldc_pkg::dp_stat_t stat,
	output logic [IW-1:0]     rd_addr,
	output logic [IW-1:0]     wr_addr,
	output logic [IW-1:0]     i_addr,
	output logic [IW-1:0]     j_addr,
	input  logic [IW-1:0]     best_idx,
	input  logic [CW-1:0]     best_len,
	input  logic [IW-1:0]     pred_rd
);
	import ldc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_INS_CMP, S_INS_PUT, S_DP_I, S_DP_IV, S_DP_J, S_DP_MOD,
		S_DP_IEND, S_EM_SET, S_EM_RD, S_EM_LAT, S_EM_OUT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] rem_q;
	logic [IW-1:0] idx_q;
	logic          last_q;
	logic          drop_q;
	logic          lastm_q;
	logic          ovf_q;
	logic [CW-1:0] cnt_dec;
	logic [CW-1:0] pos_dec2;
	logic [CW-1:0] j_inc;

	assign cnt_dec  = cnt_q - 1'b1;
	assign pos_dec2 = pos_q - CW'(2);
	assign j_inc    = j_q + 1'b1;

	always_comb begin
		cmd     = '0;
		rd_addr = '0;
		wr_addr = pos_q[IW-1:0];
		i_addr  = i_q[IW-1:0];
		j_addr  = j_q[IW-1:0];
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ld = in_valid;
				rd_addr   = cnt_dec[IW-1:0];
			end
			S_INS_CMP: begin
				rd_addr     = pos_dec2[IW-1:0];
				cmd.v_wr    = 1'b1;
				cmd.v_wr_in = !stat.rd_gt_v;
			end
			S_INS_PUT: begin
				cmd.v_wr    = 1'b1;
				cmd.v_wr_in = 1'b1;
			end
			S_DP_I: begin
				rd_addr      = i_q[IW-1:0];
				cmd.dp_init  = 1'b1;
				cmd.best_clr = (i_q == '0);
			end
			S_DP_IV: begin
				rd_addr   = j_q[IW-1:0];
				cmd.vi_ld = 1'b1;
			end
			S_DP_J: begin
				cmd.mod_start = 1'b1;
			end
			S_DP_MOD: begin
				rd_addr     = j_inc[IW-1:0];
				cmd.ext_upd = 1'b1;
			end
			S_DP_IEND: begin
				cmd.len_wr = 1'b1;
			end
			S_EM_SET: begin
			end
			S_EM_RD: begin
				rd_addr = idx_q;
			end
			S_EM_LAT: begin
				cmd.out_ld = 1'b1;
			end
			S_EM_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			rem_q   <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
			drop_q  <= 1'b0;
			lastm_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= last_item;
						i_q    <= '0;
						if (cnt_q < CW'(MAX_ITEMS)) begin
							pos_q   <= cnt_q;
							state_q <= (cnt_q == '0) ? S_INS_PUT : S_INS_CMP;
						end else begin
							// The store is full: the item is dropped and flagged.
							drop_q  <= 1'b1;
							state_q <= last_item ? S_DP_I : S_IDLE;
						end
					end
				end
				S_INS_CMP: begin
					if (stat.rd_gt_v) begin
						pos_q <= pos_q - 1'b1;
						if (pos_q == CW'(1)) begin
							state_q <= S_INS_PUT;
						end
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= last_q ? S_DP_I : S_IDLE;
					end
				end
				S_INS_PUT: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= last_q ? S_DP_I : S_IDLE;
				end
				S_DP_I: begin
					j_q     <= '0;
					state_q <= S_DP_IV;
				end
				S_DP_IV: begin
					state_q <= (i_q == '0) ? S_DP_IEND : S_DP_J;
				end
				S_DP_J: begin
					state_q <= S_DP_MOD;
				end
				S_DP_MOD: begin
					if (stat.mod_done) begin
						j_q     <= j_inc;
						state_q <= (j_inc == i_q) ? S_DP_IEND : S_DP_J;
					end
				end
				S_DP_IEND: begin
					i_q     <= i_q + 1'b1;
					state_q <= ((i_q + 1'b1) == cnt_q) ? S_EM_SET : S_DP_I;
				end
				S_EM_SET: begin
					idx_q   <= best_idx;
					rem_q   <= best_len;
					state_q <= S_EM_RD;
				end
				S_EM_RD: begin
					state_q <= S_EM_LAT;
				end
				S_EM_LAT: begin
					lastm_q <= (rem_q == CW'(1));
					ovf_q   <= drop_q;
					idx_q   <= pred_rd;
					state_q <= S_EM_OUT;
				end
				S_EM_OUT: begin
					if (out_ready) begin
						rem_q <= rem_q - 1'b1;
						if (lastm_q) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EM_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_EM_OUT);
	assign last_member = lastm_q;
	assign overflow    = ovf_q;

endmodule

[rtl/largest_divisible_chain_top.sv]
// Largest divisible chain: loads a set, finds its longest divisor chain, emits it.
// Usage: the input channel (in_valid/in_ready, value, last_item) takes one set
// element per transfer; last_item closes the set. Elements are kept sorted by
// insertion. After the closing transfer the block searches for the longest
// chain in which each element divides the next; each divisibility test runs
// through a bit-serial remainder unit. Results leave on the output channel
// (out_valid/out_ready, member, last_member, overflow), largest element first,
// each read from the store only after the previous one is taken; last_member
// marks the smallest. When the receiver stalls, the current result is held and
// no new input is taken. overflow is set on every result of a set in which
// elements were dropped because the store of MAX_ITEMS entries was full. Input
// is accepted only while the block is idle. Reset returns the block to idle
// with an empty set.
module largest_divisible_chain_top #(
	parameter int unsigned MAX_ITEMS = ldc_pkg::MAX_ITEMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ldc_pkg::VALUE_W-1:0] value,
	input  logic                        last_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ldc_pkg::VALUE_W-1:0] member,
	output logic                        last_member,
	output logic                        overflow
);
	import ldc_pkg::*;

	localparam int unsigned IW = $clog2(MAX_ITEMS);
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

	dp_cmd_t       cmd;
	dp_stat_t      stat;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] i_addr;
	logic [IW-1:0] j_addr;
	logic [IW-1:0] best_idx;
	logic [CW-1:0] best_len;
	logic [IW-1:0] pred_rd;

	ldc_ctrl #(.MAX_ITEMS(MAX_ITEMS), .IW(IW), .CW(CW)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.last_item   (last_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.last_member (last_member),
		.overflow    (overflow),
		.cmd         (cmd),
		.stat        (stat),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.i_addr      (i_addr),
		.j_addr      (j_addr),
		.best_idx    (best_idx),
		.best_len    (best_len),
		.pred_rd     (pred_rd)
	);

	ldc_dp #(.MAX_ITEMS(MAX_ITEMS), .IW(IW), .CW(CW)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.value    (value),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.i_addr   (i_addr),
		.j_addr   (j_addr),
		.best_idx (best_idx),
		.best_len (best_len),
		.pred_rd  (pred_rd),
		.member   (member)
	);

`include "largest_divisible_chain_top_assert.svh"

	`LDC_ASSERT_NOW(a_no_load_while_out, out_valid, !in_ready, "input ready while result pending")
	`LDC_ASSERT_NEXT(a_idle_after_last, out_valid && out_ready && last_member, in_ready, "not idle after final member")
	`LDC_ASSERT_NEXT(a_busy_mid_chain, out_valid && out_ready && !last_member, !in_ready, "idle in the middle of a chain")

endmodule
